[rtl/core/rcrt_pkg.sv]
package rcrt_pkg;

	localparam int unsigned CFG_IDX_W = 4;

	localparam logic [CFG_IDX_W-1:0] CFG_ROI_LEFT   = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROI_TOP    = 4'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ROI_RIGHT  = 4'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ROI_BOTTOM = 4'd3;

	localparam logic KIND_CLEAR = 1'b0;
	localparam logic KIND_RECT  = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SETUP1,
		ST_SETUP2,
		ST_READ,
		ST_UPDATE
	} ctrl_state_t;

	typedef struct packed {
		logic capture;
		logic clr_start;
		logic clr_run;
		logic load_rows;
		logic rd_en;
		logic commit;
	} dp_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic skip;
		logic slot_free;
		logic row_end;
	} dp_sts_t;

endpackage

[rtl/core/roi_crop_row_tracker.sv]
// Rectangle item: after capture come the setup states SETUP1 and SETUP2, then for each
// overlapping row, at most MAX_BLOCK_SIDE of them, a store read and then an update and
// result; an output stall holds the update. The first result is registered at the first
// update, after SETUP1, SETUP2 and a read. Clear item: one store row a cycle is zeroed.
// Reset clears the control state and the region registers, then a sweep zeroes the row
// store while item_stall stays high; configuration writes are taken always.
module roi_crop_row_tracker #(
	parameter int unsigned ROW_SLOTS      = 512,
	parameter int unsigned MAX_BLOCK_SIDE = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [rcrt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]                    cfg_data,
	input  logic                           item_valid,
	output logic                           item_stall,
	input  logic                           kind,
	input  logic [15:0]                    rect_left,
	input  logic [15:0]                    rect_top,
	input  logic [15:0]                    rect_right,
	input  logic [15:0]                    rect_bottom,
	output logic                           desc_valid,
	input  logic                           desc_stall,
	output logic [8:0]                     region_row,
	output logic [15:0]                    region_col,
	output logic [7:0]                     block_offset,
	output logic [4:0]                     copy_len,
	output logic                           row_complete,
	output logic                           all_done,
	output logic                           last
);

	rcrt_pkg::dp_cmd_t cmd;
	rcrt_pkg::dp_sts_t sts;

	assign cfg_ready = 1'b1;

	rcrt_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.kind       (kind),
		.item_stall (item_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	rcrt_dpath #(
		.ROW_SLOTS      (ROW_SLOTS),
		.MAX_BLOCK_SIDE (MAX_BLOCK_SIDE)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.rect_left    (rect_left),
		.rect_top     (rect_top),
		.rect_right   (rect_right),
		.rect_bottom  (rect_bottom),
		.cmd          (cmd),
		.sts          (sts),
		.desc_stall   (desc_stall),
		.desc_valid   (desc_valid),
		.region_row   (region_row),
		.region_col   (region_col),
		.block_offset (block_offset),
		.copy_len     (copy_len),
		.row_complete (row_complete),
		.all_done     (all_done),
		.last         (last)
	);

endmodule

[rtl/core/rcrt_ctrl.sv]
module rcrt_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	input  logic               kind,
	output logic               item_stall,
	input  rcrt_pkg::dp_sts_t  sts,
	output rcrt_pkg::dp_cmd_t  cmd
);

	rcrt_pkg::ctrl_state_t state_q;
	rcrt_pkg::ctrl_state_t state_d;

	// The row store is swept clean right after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rcrt_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		item_stall = 1'b1;
		case (state_q)
			rcrt_pkg::ST_CLEAR: begin
				cmd.clr_run = 1'b1;
				if (sts.clr_last) begin
					state_d = rcrt_pkg::ST_IDLE;
				end
			end
			rcrt_pkg::ST_IDLE: begin
				item_stall = 1'b0;
				if (item_valid) begin
					cmd.capture = 1'b1;
					if (kind == rcrt_pkg::KIND_CLEAR) begin
						cmd.clr_start = 1'b1;
						state_d       = rcrt_pkg::ST_CLEAR;
					end else begin
						state_d = rcrt_pkg::ST_SETUP1;
					end
				end
			end
			rcrt_pkg::ST_SETUP1: begin
				state_d = rcrt_pkg::ST_SETUP2;
			end
			rcrt_pkg::ST_SETUP2: begin
				cmd.load_rows = 1'b1;
				state_d = sts.skip ? rcrt_pkg::ST_IDLE : rcrt_pkg::ST_READ;
			end
			rcrt_pkg::ST_READ: begin
				cmd.rd_en = 1'b1;
				state_d   = rcrt_pkg::ST_UPDATE;
			end
			rcrt_pkg::ST_UPDATE: begin
				if (sts.slot_free) begin
					cmd.commit = 1'b1;
					state_d = sts.row_end ? rcrt_pkg::ST_IDLE : rcrt_pkg::ST_READ;
				end
			end
			default: begin
				state_d = rcrt_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

[rtl/core/rcrt_dpath.sv]
module rcrt_dpath #(
	parameter int unsigned ROW_SLOTS      = 512,
	parameter int unsigned MAX_BLOCK_SIDE = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	input  logic [rcrt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]                    cfg_data,
	input  logic [15:0]                    rect_left,
	input  logic [15:0]                    rect_top,
	input  logic [15:0]                    rect_right,
	input  logic [15:0]                    rect_bottom,
	input  rcrt_pkg::dp_cmd_t              cmd,
	output rcrt_pkg::dp_sts_t              sts,
	input  logic                           desc_stall,
	output logic                           desc_valid,
	output logic [8:0]                     region_row,
	output logic [15:0]                    region_col,
	output logic [7:0]                     block_offset,
	output logic [4:0]                     copy_len,
	output logic                           row_complete,
	output logic                           all_done,
	output logic                           last
);

	localparam int unsigned RW    = (ROW_SLOTS > 1) ? $clog2(ROW_SLOTS) : 1;
	localparam int unsigned CNT_W = $clog2(ROW_SLOTS + 1);

	// Configuration registers.
	logic [15:0] roi_left_q, roi_top_q, roi_right_q, roi_bottom_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			roi_left_q   <= '0;
			roi_top_q    <= '0;
			roi_right_q  <= '0;
			roi_bottom_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				rcrt_pkg::CFG_ROI_LEFT:   roi_left_q   <= cfg_data;
				rcrt_pkg::CFG_ROI_TOP:    roi_top_q    <= cfg_data;
				rcrt_pkg::CFG_ROI_RIGHT:  roi_right_q  <= cfg_data;
				rcrt_pkg::CFG_ROI_BOTTOM: roi_bottom_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Captured rectangle.
	logic [15:0] rl_q, rt_q, rr_q, rb_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			rl_q <= rect_left;
			rt_q <= rect_top;
			rr_q <= rect_right;
			rb_q <= rect_bottom;
		end
	end

	// First setup step: cut oversized blocks, derive region extent.
	logic [16:0]      span_w, span_h, rr_cut, rb_cut, height_raw, width_raw, bot_sum;
	logic [CNT_W-1:0] height_cut;
	logic             bad;

	logic [16:0]      rr_c_q, rb_c_q, width_q;
	logic [CNT_W-1:0] height_q;
	logic [15:0]      bot_q;
	logic             bad_q;

	always_comb begin
		span_w = {1'b0, rr_q} - {1'b0, rl_q} + 17'd1;
		span_h = {1'b0, rb_q} - {1'b0, rt_q} + 17'd1;
		rr_cut = (span_w > 17'(MAX_BLOCK_SIDE)) ?
			{1'b0, rl_q} + 17'(MAX_BLOCK_SIDE - 1) : {1'b0, rr_q};
		rb_cut = (span_h > 17'(MAX_BLOCK_SIDE)) ?
			{1'b0, rt_q} + 17'(MAX_BLOCK_SIDE - 1) : {1'b0, rb_q};
		height_raw = {1'b0, roi_bottom_q} - {1'b0, roi_top_q} + 17'd1;
		height_cut = (height_raw > 17'(ROW_SLOTS)) ? CNT_W'(ROW_SLOTS) : CNT_W'(height_raw);
		bot_sum    = {1'b0, roi_top_q} + 17'(height_cut) - 17'd1;
		width_raw  = {1'b0, roi_right_q} - {1'b0, roi_left_q} + 17'd1;
		bad = (rr_q < rl_q) || (rb_q < rt_q) ||
			(roi_right_q < roi_left_q) || (roi_bottom_q < roi_top_q);
	end

	always_ff @(posedge clk) begin
		rr_c_q   <= rr_cut;
		rb_c_q   <= rb_cut;
		height_q <= height_cut;
		bot_q    <= bot_sum[15:0];
		width_q  <= width_raw;
		bad_q    <= bad;
	end

	// Second setup step: overlap test and the clipped row and column span.
	logic        miss;
	logic [15:0] ys, ye, xs, xe, xdiff, dy16, dx16;
	logic [4:0]  cw, w;
	logic [8:0]  prod;
	logic [7:0]  off0;
	logic        finished_q;

	always_comb begin
		miss = (rr_c_q < {1'b0, roi_left_q}) || (rl_q > roi_right_q) ||
			(rb_c_q < {1'b0, roi_top_q}) || (rt_q > bot_q);
		ys    = (rt_q < roi_top_q) ? roi_top_q : rt_q;
		ye    = (rb_c_q > {1'b0, bot_q}) ? bot_q : rb_c_q[15:0];
		xs    = (rl_q < roi_left_q) ? roi_left_q : rl_q;
		xe    = (rr_c_q > {1'b0, roi_right_q}) ? roi_right_q : rr_c_q[15:0];
		xdiff = xe - xs;
		cw    = xdiff[4:0] + 5'd1;
		dx16  = rr_c_q[15:0] - rl_q;
		w     = dx16[4:0] + 5'd1;
		dy16  = ys - rt_q;
		prod  = {5'b0, dy16[3:0]} * {4'b0, w};
		dx16  = xs - rl_q;
		off0  = prod[7:0] + {4'b0, dx16[3:0]};
	end

	logic [15:0] y_q, ye_q, col_q;
	logic [4:0]  cw_q, w_q;
	logic [7:0]  off_q;

	// Row store: fill count in the low bits, completion mark on top.
	logic [16:0]      mem [ROW_SLOTS];
	logic [16:0]      rd_q;
	logic [15:0]      ry16;
	logic [RW-1:0]    clr_idx_q;
	logic [CNT_W-1:0] done_rows_q, done_inc;
	logic [16:0]      fill_sum;
	logic [15:0]      fill;
	logic             comp, stop;
	logic             desc_valid_q;

	always_comb begin
		ry16     = y_q - roi_top_q;
		fill_sum = {1'b0, rd_q[15:0]} + {12'b0, cw_q};
		fill     = fill_sum[16] ? 16'hFFFF : fill_sum[15:0];
		comp     = ({1'b0, fill} >= width_q) && !rd_q[16];
		done_inc = done_rows_q + CNT_W'(1);
		stop     = comp && (done_inc >= height_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.load_rows) begin
			y_q   <= ys;
			ye_q  <= ye;
			col_q <= xs - roi_left_q;
			cw_q  <= cw;
			w_q   <= w;
			off_q <= off0;
		end else if (cmd.commit) begin
			y_q   <= y_q + 16'd1;
			off_q <= off_q + {3'b0, w_q};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_run) begin
			mem[clr_idx_q] <= '0;
		end else if (cmd.commit) begin
			mem[ry16[RW-1:0]] <= {rd_q[16] | comp, fill};
		end
		if (cmd.rd_en) begin
			rd_q <= mem[ry16[RW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q   <= '0;
			done_rows_q <= '0;
			finished_q  <= 1'b0;
		end else if (cmd.clr_start) begin
			clr_idx_q   <= '0;
			done_rows_q <= '0;
			finished_q  <= 1'b0;
		end else begin
			if (cmd.clr_run) begin
				clr_idx_q <= clr_idx_q + RW'(1);
			end
			if (cmd.commit && comp) begin
				done_rows_q <= done_inc;
			end
			if (cmd.commit && stop) begin
				finished_q <= 1'b1;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			desc_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			desc_valid_q <= 1'b1;
		end else if (!desc_stall) begin
			desc_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			region_row   <= ry16[8:0];
			region_col   <= col_q;
			block_offset <= off_q;
			copy_len     <= cw_q;
			row_complete <= comp;
			all_done     <= stop;
			last         <= stop || (y_q == ye_q);
		end
	end

	assign desc_valid    = desc_valid_q;
	assign sts.clr_last  = (clr_idx_q == RW'(ROW_SLOTS - 1));
	assign sts.skip      = finished_q || bad_q || miss;
	assign sts.slot_free = !desc_valid_q || !desc_stall;
	assign sts.row_end   = stop || (y_q == ye_q);

endmodule
